### sv/pwpt_pkg.sv
// Shared types and constants of the pulse-width packet transmitter.
package pwpt_pkg;

	localparam int WordWidth = 32;
	localparam int TickWidth = 8;
	localparam int CmpWidth = (TickWidth > 8) ? TickWidth : 8;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 8;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [TickWidth-1:0] tick_t;
	typedef logic [CmpWidth-1:0] cmp_t;
	typedef logic [CfgIndexWidth-1:0] cfg_index_t;
	typedef logic [CfgDataWidth-1:0] cfg_data_t;

	// Configuration register indexes.
	localparam cfg_index_t CfgOneHigh = 3'd0;
	localparam cfg_index_t CfgZeroHigh = 3'd1;
	localparam cfg_index_t CfgGap = 3'd2;
	localparam cfg_index_t CfgPacketBits = 3'd3;
	localparam cfg_index_t CfgRepeatCount = 3'd4;

	// Register values after reset.
	localparam logic [6:0] OneHighReset = 7'd20;
	localparam logic [6:0] ZeroHighReset = 7'd10;
	localparam logic [7:0] GapReset = 8'd40;
	localparam logic [5:0] PacketBitsReset = 6'd19;
	localparam logic [3:0] RepeatCountReset = 4'd6;

	typedef struct packed {
		logic [6:0] one_high_ticks;
		logic [6:0] zero_high_ticks;
		logic [7:0] gap_ticks;
		logic [5:0] packet_bits;
		logic [3:0] repeat_count;
	} cfg_t;

	typedef struct packed {
		logic       line;
		logic       busy_res;
		logic [3:0] repeats_done;
	} res_t;

endpackage

### sv/pwpt_cfg_regs.sv
// Configuration register file of the pulse-width packet transmitter.
module pwpt_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pwpt_pkg::cfg_index_t cfg_index,
	input  pwpt_pkg::cfg_data_t  cfg_data,
	output pwpt_pkg::cfg_t       cfg
);

	pwpt_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_high_ticks <= pwpt_pkg::OneHighReset;
			cfg_q.zero_high_ticks <= pwpt_pkg::ZeroHighReset;
			cfg_q.gap_ticks <= pwpt_pkg::GapReset;
			cfg_q.packet_bits <= pwpt_pkg::PacketBitsReset;
			cfg_q.repeat_count <= pwpt_pkg::RepeatCountReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pwpt_pkg::CfgOneHigh: cfg_q.one_high_ticks <= cfg_data[6:0];
				pwpt_pkg::CfgZeroHigh: cfg_q.zero_high_ticks <= cfg_data[6:0];
				pwpt_pkg::CfgGap: cfg_q.gap_ticks <= cfg_data;
				pwpt_pkg::CfgPacketBits: cfg_q.packet_bits <= cfg_data[5:0];
				pwpt_pkg::CfgRepeatCount: cfg_q.repeat_count <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

### sv/pwpt_core.sv
// Transmit sequencer: state registers and the per-request state update.
module pwpt_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             kind,
	input  pwpt_pkg::word_t  packet,
	input  pwpt_pkg::cfg_t   cfg,
	output pwpt_pkg::res_t   res
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START   = 4'd1,
		PH_ONE_HI  = 4'd2,
		PH_ZERO_HI = 4'd3,
		PH_ONE_LO  = 4'd4,
		PH_ZERO_LO = 4'd5,
		PH_DELAY   = 4'd8
	} phase_t;

	localparam pwpt_pkg::tick_t TickMax = '1;

	phase_t          phase_q, phase_d;
	pwpt_pkg::tick_t tick_q, tick_d;
	pwpt_pkg::word_t pending_q, pending_d;
	pwpt_pkg::word_t shift_q, shift_d;
	logic [5:0]      bits_q, bits_d;
	logic [3:0]      packets_q, packets_d;
	logic            line_q, line_d;

	// Phases are evaluated in a fixed order, so a phase entered earlier in the
	// chain acts within the same tick.
	always_comb begin
		logic advance;
		advance = 1'b0;
		phase_d = phase_q;
		tick_d = tick_q;
		pending_d = pending_q;
		shift_d = shift_q;
		bits_d = bits_q;
		packets_d = packets_q;
		line_d = line_q;
		if (kind) begin
			pending_d = packet;
			packets_d = 4'd0;
			phase_d = PH_START;
		end else begin
			if (tick_d != TickMax) begin
				tick_d = tick_d + 1'b1;
			end
			if (phase_d == PH_START) begin
				tick_d = '0;
				bits_d = 6'd0;
				shift_d = pending_d;
				line_d = 1'b1;
				phase_d = shift_d[0] ? PH_ONE_HI : PH_ZERO_HI;
			end
			if (phase_d == PH_ONE_HI) begin
				line_d = 1'b1;
				if (pwpt_pkg::cmp_t'(tick_d) > pwpt_pkg::cmp_t'(cfg.one_high_ticks)) begin
					phase_d = PH_ONE_LO;
				end
			end
			if (phase_d == PH_ZERO_HI) begin
				line_d = 1'b1;
				if (pwpt_pkg::cmp_t'(tick_d) > pwpt_pkg::cmp_t'(cfg.zero_high_ticks)) begin
					phase_d = PH_ZERO_LO;
				end
			end
			if (phase_d == PH_ONE_LO) begin
				line_d = 1'b0;
				if (pwpt_pkg::cmp_t'(tick_d) > pwpt_pkg::cmp_t'({cfg.one_high_ticks, 1'b0})) begin
					advance = 1'b1;
				end
			end
			if (phase_d == PH_ZERO_LO) begin
				line_d = 1'b0;
				if (pwpt_pkg::cmp_t'(tick_d) > pwpt_pkg::cmp_t'({cfg.zero_high_ticks, 1'b0})) begin
					advance = 1'b1;
				end
			end
			if (advance) begin
				shift_d = shift_d >> 1;
				bits_d = bits_d + 6'd1;
				tick_d = '0;
				if (bits_d < cfg.packet_bits) begin
					phase_d = shift_d[0] ? PH_ONE_HI : PH_ZERO_HI;
				end else begin
					packets_d = packets_d + 4'd1;
					if (packets_d < cfg.repeat_count) begin
						phase_d = PH_DELAY;
					end else begin
						packets_d = 4'd0;
						phase_d = PH_IDLE;
					end
				end
			end
			if (phase_d == PH_DELAY) begin
				// A gap longer than the counter can hold ends at saturation.
				if (pwpt_pkg::cmp_t'(tick_d) > pwpt_pkg::cmp_t'(cfg.gap_ticks) ||
						tick_d == TickMax) begin
					phase_d = PH_START;
				end
			end
		end
	end

	assign res.line = line_d;
	assign res.busy_res = (phase_d != PH_IDLE);
	assign res.repeats_done = packets_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			pending_q <= '0;
			shift_q <= '0;
			bits_q <= 6'd0;
			packets_q <= 4'd0;
			line_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			pending_q <= pending_d;
			shift_q <= shift_d;
			bits_q <= bits_d;
			packets_q <= packets_d;
			line_q <= line_d;
		end
	end

endmodule

### sv/pulse_width_packet_transmitter_unit.sv
// Pulse-width packet transmitter: input register, sequencer and result register.
// A request is held in the input register and its result is offered from the result register.
// One request per cycle while the result register is not stalled.
// A stalled result register holds; one request waits in the input register meanwhile.
// Reset (arst_n low, asynchronous) empties both registers, idles the sequencer
// with the line low, and loads the configuration defaults.
module pulse_width_packet_transmitter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [31:0]          packet,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 line,
	output logic                 busy_res,
	output logic [3:0]           repeats_done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  pwpt_pkg::cfg_index_t cfg_index,
	input  pwpt_pkg::cfg_data_t  cfg_data
);

	pwpt_pkg::cfg_t  cfg;
	pwpt_pkg::res_t  res;
	logic            valid_s1;
	logic            kind_s1;
	pwpt_pkg::word_t packet_s1;
	logic            out_valid_q;
	pwpt_pkg::res_t  res_q;
	logic            step;

	assign step = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	pwpt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.kind   (kind_s1),
		.packet (packet_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			packet_s1 <= packet;
		end
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign line = res_q.line;
	assign busy_res = res_q.busy_res;
	assign repeats_done = res_q.repeats_done;

`ifndef SYNTH
	// An idle sequencer always reports a low line and no completed repeats.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_res) |-> (!line && repeats_done == 4'd0))
		else $error("idle result with line high or repeats counted");

	// A waiting request moves into an empty result register at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("request not advanced into empty result register");

	// A stalled result keeps both the result and the waiting request in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1) |=> (valid_s1 && out_valid_q))
		else $error("waiting request lost during output stall");
`endif

endmodule
